[rtl/tkipmix_pkg.sv]
// Shared types, constants and helper functions for the TKIP key mixing block.
// Holds the 16-bit S-box, the request/response structs and the sequencer states.
// No dependencies.
package tkipmix_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_TK_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TK_HIGH = 2'd1;

  localparam logic [7:0] TSC1_SET_MASK = 8'h20;
  localparam logic [7:0] TSC1_KEEP_MASK = 8'h7F;

  typedef struct packed {
    logic [47:0] tsc;
    logic [47:0] transmitter_address;
  } tkip_req_t;

  typedef struct packed {
    logic [63:0] rc4_key_low;
    logic [63:0] rc4_key_high;
    logic        phase1_recomputed;
  } tkip_rsp_t;

  // Control for one pass through the shared mixing unit.
  typedef struct packed {
    logic       use_sbox;
    logic [2:0] add_const;
  } step_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE1,
    ST_MIX_LOW,
    ST_PHASE2,
    ST_OUT
  } tkip_state_t;

  localparam logic [15:0] SBOX [256] = '{
    16'hC6A5, 16'hF884, 16'hEE99, 16'hF68D, 16'hFF0D, 16'hD6BD, 16'hDEB1, 16'h9154,
    16'h6050, 16'h0203, 16'hCEA9, 16'h567D, 16'hE719, 16'hB562, 16'h4DE6, 16'hEC9A,
    16'h8F45, 16'h1F9D, 16'h8940, 16'hFA87, 16'hEF15, 16'hB2EB, 16'h8EC9, 16'hFB0B,
    16'h41EC, 16'hB367, 16'h5FFD, 16'h45EA, 16'h23BF, 16'h53F7, 16'hE496, 16'h9B5B,
    16'h75C2, 16'hE11C, 16'h3DAE, 16'h4C6A, 16'h6C5A, 16'h7E41, 16'hF502, 16'h834F,
    16'h685C, 16'h51F4, 16'hD134, 16'hF908, 16'hE293, 16'hAB73, 16'h6253, 16'h2A3F,
    16'h080C, 16'h9552, 16'h4665, 16'h9D5E, 16'h3028, 16'h37A1, 16'h0A0F, 16'h2FB5,
    16'h0E09, 16'h2436, 16'h1B9B, 16'hDF3D, 16'hCD26, 16'h4E69, 16'h7FCD, 16'hEA9F,
    16'h121B, 16'h1D9E, 16'h5874, 16'h342E, 16'h362D, 16'hDCB2, 16'hB4EE, 16'h5BFB,
    16'hA4F6, 16'h764D, 16'hB761, 16'h7DCE, 16'h527B, 16'hDD3E, 16'h5E71, 16'h1397,
    16'hA6F5, 16'hB968, 16'h0000, 16'hC12C, 16'h4060, 16'hE31F, 16'h79C8, 16'hB6ED,
    16'hD4BE, 16'h8D46, 16'h67D9, 16'h724B, 16'h94DE, 16'h98D4, 16'hB0E8, 16'h854A,
    16'hBB6B, 16'hC52A, 16'h4FE5, 16'hED16, 16'h86C5, 16'h9AD7, 16'h6655, 16'h1194,
    16'h8ACF, 16'hE910, 16'h0406, 16'hFE81, 16'hA0F0, 16'h7844, 16'h25BA, 16'h4BE3,
    16'hA2F3, 16'h5DFE, 16'h80C0, 16'h058A, 16'h3FAD, 16'h21BC, 16'h7048, 16'hF104,
    16'h63DF, 16'h77C1, 16'hAF75, 16'h4263, 16'h2030, 16'hE51A, 16'hFD0E, 16'hBF6D,
    16'h814C, 16'h1814, 16'h2635, 16'hC32F, 16'hBEE1, 16'h35A2, 16'h88CC, 16'h2E39,
    16'h9357, 16'h55F2, 16'hFC82, 16'h7A47, 16'hC8AC, 16'hBAE7, 16'h322B, 16'hE695,
    16'hC0A0, 16'h1998, 16'h9ED1, 16'hA37F, 16'h4466, 16'h547E, 16'h3BAB, 16'h0B83,
    16'h8CCA, 16'hC729, 16'h6BD3, 16'h283C, 16'hA779, 16'hBCE2, 16'h161D, 16'hAD76,
    16'hDB3B, 16'h6456, 16'h744E, 16'h141E, 16'h92DB, 16'h0C0A, 16'h486C, 16'hB8E4,
    16'h9F5D, 16'hBD6E, 16'h43EF, 16'hC4A6, 16'h39A8, 16'h31A4, 16'hD337, 16'hF28B,
    16'hD532, 16'h8B43, 16'h6E59, 16'hDAB7, 16'h018C, 16'hB164, 16'h9CD2, 16'h49E0,
    16'hD8B4, 16'hACFA, 16'hF307, 16'hCF25, 16'hCAAF, 16'hF48E, 16'h47E9, 16'h1018,
    16'h6FD5, 16'hF088, 16'h4A6F, 16'h5C72, 16'h3824, 16'h57F1, 16'h73C7, 16'h9751,
    16'hCB23, 16'hA17C, 16'hE89C, 16'h3E21, 16'h96DD, 16'h61DC, 16'h0D86, 16'h0F85,
    16'hE090, 16'h7C42, 16'h71C4, 16'hCCAA, 16'h90D8, 16'h0605, 16'hF701, 16'h1C12,
    16'hC2A3, 16'h6A5F, 16'hAEF9, 16'h69D0, 16'h1791, 16'h9958, 16'h3A27, 16'h27B9,
    16'hD938, 16'hEB13, 16'h2BB3, 16'h2233, 16'hD2BB, 16'hA970, 16'h0789, 16'h33A7,
    16'h2DB6, 16'h3C22, 16'h1592, 16'hC920, 16'h8749, 16'hAAFF, 16'h5078, 16'hA57A,
    16'h038F, 16'h59F8, 16'h0980, 16'h1A17, 16'h65DA, 16'hD731, 16'h84C6, 16'hD0B8,
    16'h82C3, 16'h29B0, 16'h5A77, 16'h1E11, 16'h7BCB, 16'hA8FC, 16'h6DD6, 16'h2C3A
  };

  function automatic logic [15:0] sub16(input logic [15:0] v);
    logic [15:0] t;
    t = SBOX[v[15:8]];
    return SBOX[v[7:0]] ^ {t[7:0], t[15:8]};
  endfunction

  function automatic logic [15:0] rotr1(input logic [15:0] v);
    return {v[0], v[15:1]};
  endfunction

  // Key word m holds key bytes 2m (low) and 2m+1 (high).
  function automatic logic [15:0] key_word(input logic [63:0] tk_low,
                                           input logic [63:0] tk_high,
                                           input logic [2:0]  m);
    logic [63:0] r;
    logic [15:0] w;
    r = m[2] ? tk_high : tk_low;
    unique case (m[1:0])
      2'd0: w = r[15:0];
      2'd1: w = r[31:16];
      2'd2: w = r[47:32];
      default: w = r[63:48];
    endcase
    return w;
  endfunction

endpackage

[rtl/tkipmix_step.sv]
// Shared mixing unit: one S-box or rotate step of the key mixing per cycle.
// Depends on tkipmix_pkg for the S-box, the rotate and the step control struct.
module tkipmix_step import tkipmix_pkg::*; (
  input  logic [15:0] acc,
  input  logic [15:0] src,
  input  logic [15:0] kw,
  input  step_op_t    op,
  output logic [15:0] result
);

  logic [15:0] mixed;
  logic [15:0] f;

  assign mixed = src ^ kw;
  assign f = op.use_sbox ? sub16(mixed) : rotr1(mixed);
  assign result = acc + f + {13'd0, op.add_const};

endmodule

[rtl/tkip_per_packet_key_mixing.sv]
// Top level of the TKIP two-phase per-packet key mixing block.
// Depends on tkipmix_pkg and tkipmix_step.
//
// Usage:
//   Write the temporal key through cfg_write / cfg_index / cfg_data while the
//   block is idle: index 0 takes key bytes 0..7, index 1 bytes 8..15. Either
//   write drops the cached phase-1 result.
//   A request (req_valid/req_ready) carries the TSC and transmitter address.
//   req_ready is high only while the sequencer is idle; one request is in
//   flight at a time. The response (rsp_valid/rsp_ready) carries the 128-bit
//   RC4 key and a flag that tells whether phase 1 ran.
//   After acceptance, a cache hit computes the low TTAK sum, runs the 12
//   phase-2 steps and then loads the output register for rsp_valid; a miss
//   first runs the 40 phase-1 steps. Both phases run on the one shared
//   mixing unit, one 16-bit step per cycle.
//   When the receiver stalls, the finished key waits in the output register;
//   the sequencer holds in its output state until the register frees up.
//   Reset (rst, synchronous) clears the key, the cache flag, the sequencer
//   state and rsp_valid; no response is pending afterwards.
module tkip_per_packet_key_mixing import tkipmix_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  tkip_req_t              req,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output tkip_rsp_t              rsp,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  tkip_state_t state, state_next;

  logic [63:0] tk_low;
  logic [63:0] tk_high;

  // Phase-1 cache.
  logic [15:0] cached_mix [5];
  logic [31:0] cached_high_counter;
  logic [47:0] cached_address;
  logic        cache_valid;

  // Working ring: words rotate one place per step so the unit always
  // reads position 0 as accumulator and the last position as source.
  logic [15:0] w [6];
  logic [15:0] tsc_low;
  logic        recomputed;

  logic [2:0]  p1_word;
  logic [2:0]  p1_round;
  logic [3:0]  p2_step;

  logic        req_fire;
  logic        cache_hit;
  logic        out_load;
  logic        p1_last;
  logic        p2_last;

  logic [15:0] unit_src;
  logic [15:0] unit_kw;
  step_op_t    unit_op;
  logic [15:0] unit_res;

  logic [15:0] final_kw0;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [7:0]  b3;

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign cache_hit = cache_valid && (req.tsc[47:16] == cached_high_counter)
                     && (req.transmitter_address == cached_address);
  assign p1_last   = (p1_word == 3'd4) && (p1_round == 3'd7);
  assign p2_last   = (p2_step == 4'd11);
  assign out_load  = (state == ST_OUT) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          state_next = cache_hit ? ST_MIX_LOW : ST_PHASE1;
        end
      end
      ST_PHASE1: begin
        if (p1_last) begin
          state_next = ST_MIX_LOW;
        end
      end
      ST_MIX_LOW: state_next = ST_PHASE2;
      ST_PHASE2: begin
        if (p2_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Operand selection for the shared unit.
  always_comb begin
    if (state == ST_PHASE1) begin
      unit_src          = w[4];
      unit_kw           = key_word(tk_low, tk_high, {p1_word[1:0], p1_round[0]});
      unit_op.use_sbox  = 1'b1;
      unit_op.add_const = (p1_word == 3'd4) ? p1_round : 3'd0;
    end else begin
      unit_src          = w[5];
      unit_kw           = (p2_step < 4'd8) ? key_word(tk_low, tk_high, p2_step[2:0])
                                           : 16'd0;
      unit_op.use_sbox  = (p2_step < 4'd6);
      unit_op.add_const = 3'd0;
    end
  end

  tkipmix_step u_step (
    .acc    (w[0]),
    .src    (unit_src),
    .kw     (unit_kw),
    .op     (unit_op),
    .result (unit_res)
  );

  // Key registers and cache flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      tk_low      <= '0;
      tk_high     <= '0;
      cache_valid <= 1'b0;
    end else begin
      if (state == ST_MIX_LOW && recomputed) begin
        cache_valid <= 1'b1;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_TK_LOW: begin
            tk_low      <= cfg_data;
            cache_valid <= 1'b0;
          end
          REG_TK_HIGH: begin
            tk_high     <= cfg_data;
            cache_valid <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Working ring, counters and cache contents.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          tsc_low    <= req.tsc[15:0];
          recomputed <= !cache_hit;
          p1_word    <= 3'd0;
          p1_round   <= 3'd0;
          p2_step    <= 4'd0;
          if (cache_hit) begin
            for (int i = 0; i < 5; i++) begin
              w[i] <= cached_mix[i];
            end
          end else begin
            w[0]                <= req.tsc[31:16];
            w[1]                <= req.tsc[47:32];
            w[2]                <= req.transmitter_address[15:0];
            w[3]                <= req.transmitter_address[31:16];
            w[4]                <= req.transmitter_address[47:32];
            cached_high_counter <= req.tsc[47:16];
            cached_address      <= req.transmitter_address;
          end
        end
      end
      ST_PHASE1: begin
        // Rotate the five-word ring; the new word lands at the end.
        for (int i = 0; i < 4; i++) begin
          w[i] <= w[i+1];
        end
        w[4] <= unit_res;
        if (p1_word == 3'd4) begin
          p1_word  <= 3'd0;
          p1_round <= p1_round + 3'd1;
        end else begin
          p1_word <= p1_word + 3'd1;
        end
      end
      ST_MIX_LOW: begin
        w[5] <= w[4] + tsc_low;
        if (recomputed) begin
          for (int i = 0; i < 5; i++) begin
            cached_mix[i] <= w[i];
          end
        end
      end
      ST_PHASE2: begin
        // Rotate the six-word ring.
        for (int i = 0; i < 5; i++) begin
          w[i] <= w[i+1];
        end
        w[5]    <= unit_res;
        p2_step <= p2_step + 4'd1;
      end
      default: ;
    endcase
  end

  // Output byte assembly.
  assign final_kw0 = w[5] ^ key_word(tk_low, tk_high, 3'd0);
  assign b0 = tsc_low[15:8];
  assign b1 = (b0 | TSC1_SET_MASK) & TSC1_KEEP_MASK;
  assign b2 = tsc_low[7:0];
  assign b3 = final_kw0[8:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.rc4_key_low       <= {w[1], w[0], b3, b2, b1, b0};
      rsp.rc4_key_high      <= {w[5], w[4], w[3], w[2]};
      rsp.phase1_recomputed <= recomputed;
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for tkip_per_packet_key_mixing: runs TKIP packet requests
// through the block and checks every per-packet key against a predictor in the bench.
// Depends on tkipmix_pkg for the request/response types, register indexes and S-box.
`timescale 1ns / 100ps

module tb;
  import tkipmix_pkg::*;

  // Spare register indexes: writes to these must leave key and cache alone
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  // Worst run is roughly 850 requests, each with its busy time, sender gap and
  // receiver stall, plus one long hold-off; this limit leaves several times that.
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_ready;
  tkip_req_t              req;
  logic                   rsp_valid;
  logic                   rsp_ready;
  tkip_rsp_t              rsp;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [63:0]            cfg_data;

  // Idling controls for the request sender and the key receiver, and run counters
  bit sender_gaps;
  bit receiver_gaps;
  int hold_request;
  int mismatch_count;
  int cycle_count;

  // Predictor copy of the temporal key and the phase-1 cache
  logic [63:0] tk_low;
  logic [63:0] tk_high;
  logic [15:0] p1_mix [5];
  logic [31:0] p1_high;
  logic [47:0] p1_addr;
  bit          p1_valid;

  // Keys the block still owes, oldest first
  tkip_rsp_t key_fifo[$];

  tkip_per_packet_key_mixing DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Key mixing predictor
  // ---------------------------------------------------------------------------

  // 16-bit substitution: low byte straight through the table, high byte through
  // the table with its two halves swapped.
  function automatic logic [15:0] sbox_sub(input logic [15:0] v);
    logic [15:0] hi_entry;
    hi_entry = SBOX[v[15:8]];
    return SBOX[v[7:0]] ^ {hi_entry[7:0], hi_entry[15:8]};
  endfunction

  function automatic logic [15:0] ror16(input logic [15:0] v);
    return {v[0], v[15:1]};
  endfunction

  // Word m of the temporal key: key bytes 2m and 2m+1
  function automatic logic [15:0] tk_word(input int m);
    logic [127:0] tk;
    tk = {tk_high, tk_low};
    return tk[16*m +: 16];
  endfunction

  // Work out the key for one request and advance the cache the way the block must
  function automatic tkip_rsp_t mix_packet_key(input tkip_req_t r);
    logic [31:0] hi;
    logic [15:0] lo;
    logic [15:0] p [5];
    logic [15:0] k [6];
    logic [15:0] k5_key;
    logic [7:0]  b1;
    tkip_rsp_t   o;
    hi = r.tsc[47:16];
    lo = r.tsc[15:0];
    o.phase1_recomputed = 1'b0;

    // Phase 1 only on a cold cache or a new high counter / address
    if (!p1_valid || hi != p1_high || r.transmitter_address != p1_addr) begin
      p[0] = hi[15:0];
      p[1] = hi[31:16];
      p[2] = r.transmitter_address[15:0];
      p[3] = r.transmitter_address[31:16];
      p[4] = r.transmitter_address[47:32];
      for (int i = 0; i < 8; i++) begin
        p[0] = p[0] + sbox_sub(p[4] ^ tk_word(i & 1));
        p[1] = p[1] + sbox_sub(p[0] ^ tk_word(2 + (i & 1)));
        p[2] = p[2] + sbox_sub(p[1] ^ tk_word(4 + (i & 1)));
        p[3] = p[3] + sbox_sub(p[2] ^ tk_word(6 + (i & 1)));
        p[4] = p[4] + sbox_sub(p[3] ^ tk_word(i & 1)) + 16'(i);
      end
      for (int i = 0; i < 5; i++) p1_mix[i] = p[i];
      p1_high = hi;
      p1_addr = r.transmitter_address;
      p1_valid = 1'b1;
      o.phase1_recomputed = 1'b1;
    end

    // Phase 2: each word absorbs the one before it (word 0 wraps to word 5)
    for (int i = 0; i < 5; i++) k[i] = p1_mix[i];
    k[5] = k[4] + lo;
    for (int i = 0; i < 6; i++)
      k[i] = k[i] + sbox_sub(k[(i + 5) % 6] ^ tk_word(i));
    for (int i = 0; i < 6; i++)
      k[i] = k[i] + ror16(k[(i + 5) % 6] ^ ((i < 2) ? tk_word(6 + i) : 16'h0000));

    // Leading bytes: TSC1, the weak-key-avoiding copy of TSC1, TSC0, then the
    // key-dependent fourth byte
    b1 = (lo[15:8] | TSC1_SET_MASK) & TSC1_KEEP_MASK;
    k5_key = k[5] ^ tk_word(0);
    o.rc4_key_low  = {k[1], k[0], k5_key[8:1], lo[7:0], b1, lo[15:8]};
    o.rc4_key_high = {k[5], k[4], k[3], k[2]};
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%t mismatch: %s", $realtime, msg);
  endfunction

  // Compare each accepted key against the oldest one owed
  always @(posedge clk) begin
    tkip_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (key_fifo.size() == 0) begin
        flag_mismatch($sformatf("key %h_%h p1 %b with no request pending",
                                rsp.rc4_key_high, rsp.rc4_key_low, rsp.phase1_recomputed));
      end else begin
        want = key_fifo.pop_front();
        if (rsp.rc4_key_low !== want.rc4_key_low || rsp.rc4_key_high !== want.rc4_key_high ||
            rsp.phase1_recomputed !== want.phase1_recomputed)
          flag_mismatch($sformatf("exp key %h_%h p1 %b, got key %h_%h p1 %b",
                                  want.rc4_key_high, want.rc4_key_low,
                                  want.phase1_recomputed, rsp.rc4_key_high,
                                  rsp.rc4_key_low, rsp.phase1_recomputed));
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off when a test asks for one
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && receiver_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request and register drivers
  // ---------------------------------------------------------------------------

  function automatic logic [47:0] rand48();
    return {16'($urandom()), $urandom()};
  endfunction

  // Offer one request and hold it until accepted. Valid stays high on return so
  // a back-to-back request follows without a bubble; drain_keys drops it.
  task automatic send_packet(input logic [47:0] tsc, input logic [47:0] addr);
    tkip_req_t r;
    r.tsc = tsc;
    r.transmitter_address = addr;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    key_fifo.push_back(mix_packet_key(r));
  endtask

  // Drop valid and wait until every owed key has come back
  task automatic drain_keys();
    req_valid <= 1'b0;
    while (key_fifo.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes only happen with the block idle
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    drain_keys();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TK_LOW: begin
        tk_low = data;
        p1_valid = 1'b0;
      end
      REG_TK_HIGH: begin
        tk_high = data;
        p1_valid = 1'b0;
      end
      default: ;  // spare index: key and cache untouched
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero key straight out of reset. Only the predictor's cache tags start at zero,
  // so an all-zero request must still run phase 1 because the cache is not valid.
  task automatic test_reset_state();
    send_packet(48'h0, 48'h0);
    send_packet(48'h0, 48'h0);
    send_packet(48'h0000_0000_FFFF, 48'h0);
    send_packet(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_packet(48'hFFFF_FFFF_0000, 48'hFFFF_FFFF_FFFF);
  endtask

  // Any key write drops the cache, even with an unchanged counter and address
  task automatic test_key_writes();
    write_register(REG_TK_LOW, '1);
    write_register(REG_TK_HIGH, '1);
    send_packet(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_packet(48'hFFFF_FFFF_00FF, 48'hFFFF_FFFF_FFFF);
    write_register(REG_TK_HIGH, '0);
    send_packet(48'hFFFF_FFFF_00FF, 48'hFFFF_FFFF_FFFF);
    write_register(REG_TK_LOW, 64'hA5A5_5A5A_0F0F_F0F0);
    write_register(REG_TK_HIGH, 64'h5A5A_A5A5_F0F0_0F0F);
    send_packet(48'hFFFF_FFFF_00FF, 48'hFFFF_FFFF_FFFF);
  endtask

  // Writes to spare indexes are ignored: the cache must still hit
  task automatic test_unknown_index();
    write_register(REG_SPARE_A, '1);
    write_register(REG_SPARE_B, {$urandom(), $urandom()});
    send_packet(48'hFFFF_FFFF_00FF, 48'hFFFF_FFFF_FFFF);
    send_packet(48'hFFFF_FFFF_1234, 48'hFFFF_FFFF_FFFF);
  endtask

  // Cache tag rules: low counter wrap, address-only and counter-only changes,
  // and the masking of the weak-key byte
  task automatic test_cache_rules();
    send_packet(48'h1234_5678_FFFE, 48'h0211_2233_4455);
    send_packet(48'h1234_5678_FFFF, 48'h0211_2233_4455);
    send_packet(48'h1234_5679_0000, 48'h0211_2233_4455);
    send_packet(48'h1234_5679_0001, 48'h0311_2233_4455);
    send_packet(48'h1234_5678_0002, 48'h0311_2233_4455);
    send_packet(48'h1234_5678_8000, 48'h0311_2233_4455);
    send_packet(48'h1234_5678_DF7F, 48'h0311_2233_4455);
    send_packet(48'h0000_0000_2020, 48'hFFFF_FFFF_FFFF);
    send_packet(48'h8000_0001_5F5F, 48'h8000_0000_0001);
  endtask

  // Hold the receiver off long enough for the block to fill and block requests
  task automatic test_backpressure();
    logic [47:0] tsc;
    logic [47:0] addr;
    drain_keys();
    tsc = rand48();
    addr = rand48();
    sender_gaps = 1'b0;
    hold_request = LONG_HOLD;
    repeat (8) begin
      send_packet(tsc, addr);
      tsc = tsc + 48'd1;
    end
    sender_gaps = 1'b1;
    drain_keys();
  endtask

  // Mostly per-station packet runs with climbing counters (cache hits, with
  // runs that cross a high-counter boundary), plus unrelated packets and
  // replays of an older high counter.
  task automatic run_station_traffic(input int n_items);
    int sent;
    int len;
    int kind;
    logic [47:0] addr;
    logic [47:0] tsc;
    sent = 0;
    addr = rand48();
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_packet(rand48(), rand48());
        sent++;
      end else begin
        if (kind <= 3) addr = rand48();
        tsc = rand48();
        if (kind == 4 || kind == 5) tsc[15:0] = 16'hFFFF - 16'($urandom_range(0, 4));
        len = $urandom_range(1, 20);
        repeat (len) begin
          send_packet(tsc, addr);
          sent++;
          tsc = tsc + 48'($urandom_range(1, 2));
        end
        if (kind == 9) begin
          send_packet(tsc - 48'h1_0000, addr);
          sent++;
        end
      end
    end
  endtask

  // Several key settings; single-register writes and spare writes in between
  task automatic test_random_traffic();
    write_register(REG_TK_LOW, {$urandom(), $urandom()});
    write_register(REG_TK_HIGH, {$urandom(), $urandom()});
    run_station_traffic(150);
    write_register(REG_TK_LOW, '0);
    run_station_traffic(150);
    write_register(REG_TK_HIGH, '1);
    write_register(REG_SPARE_B, {$urandom(), $urandom()});
    run_station_traffic(150);
    write_register(REG_TK_LOW, {$urandom(), $urandom()});
    write_register(REG_TK_HIGH, {$urandom(), $urandom()});
    write_register(REG_SPARE_A, {$urandom(), $urandom()});
    run_station_traffic(150);
    write_register(REG_TK_HIGH, {$urandom(), $urandom()});
    run_station_traffic(150);
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_no_idling();
    drain_keys();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    write_register(REG_TK_LOW, {$urandom(), $urandom()});
    run_station_traffic(60);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_TK_LOW;
    cfg_data <= '0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    hold_request = 0;
    mismatch_count = 0;

    // Predictor starts from the reset state
    tk_low = '0;
    tk_high = '0;
    for (int i = 0; i < 5; i++) p1_mix[i] = '0;
    p1_high = '0;
    p1_addr = '0;
    p1_valid = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_key_writes();
    test_unknown_index();
    test_cache_rules();
    test_backpressure();
    test_random_traffic();
    test_no_idling();

    // Let any stray key show up before the verdict
    drain_keys();
    repeat (64) @(posedge clk);

    if (mismatch_count == 0 && key_fifo.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
rtl/tkipmix_pkg.sv
rtl/tkipmix_step.sv
rtl/tkip_per_packet_key_mixing.sv
tb/tb.sv
